// ----- rtl/ffca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg: shared definitions of the first-fit contiguous allocator
// Field widths, cell geometry and the structs that run along the cell chain.
// ----------------------------------------------------------------------------
package ffca_pkg;

  // Widths of the transaction fields
  localparam int LEN_W = 11;
  localparam int IDX_W = 10;

  // Free map bits held by one cell, and the width of a bit offset in a cell
  localparam int CELL_W  = 16;
  localparam int CELL_IW = $clog2(CELL_W);

  // Default map size and the block count after reset
  localparam int                 FFCA_MAX_BLOCKS = 1024;
  localparam logic [LEN_W-1:0]   DISK_BLOCKS_RST = 11'd1024;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic             set;      // mark set_pos free
    logic [LEN_W-1:0] set_pos;
    logic             clr;      // mark [clr_lo, clr_hi) used
    logic [LEN_W-1:0] clr_lo;
    logic [LEN_W:0]   clr_hi;
    logic [LEN_W-1:0] len;      // requested run length of the scan
    logic [LEN_W-1:0] lim;      // usable block count
  } ffca_bcast_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic             act;      // token present
    logic             found;    // a run was found upstream
    logic [LEN_W-1:0] run;      // free blocks ending at the previous cell
    logic [LEN_W-1:0] start;    // start of the found run
  } ffca_tok_t;

endpackage

// ----- rtl/ffca_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_req_if: request channel
// Valid/ready channel that carries load and allocate requests.
// ----------------------------------------------------------------------------
interface ffca_req_if import ffca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] block_index;
  logic [LEN_W-1:0] request_length;

  modport source (output valid, output mode, output block_index,
                  output request_length, input ready);
  modport sink   (input valid, input mode, input block_index,
                  input request_length, output ready);
endinterface

// ----- rtl/ffca_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_rsp_if: response channel
// Valid/ready channel that carries the outcome of an allocation.
// ----------------------------------------------------------------------------
interface ffca_rsp_if import ffca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             granted;
  logic [IDX_W-1:0] start_block;
  logic [LEN_W-1:0] grant_length;

  modport source (output valid, output granted, output start_block,
                  output grant_length, input ready);
  modport sink   (input valid, input granted, input start_block,
                  input grant_length, output ready);
endinterface

// ----- rtl/ffca_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_cell: one slice of the free map
// Holds CELL_W free bits starting at block BASE, applies set and clear
// broadcasts, and advances the scan token by one cell per cycle.
// ----------------------------------------------------------------------------
module ffca_cell import ffca_pkg::*; #(
  parameter int BASE = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ffca_bcast_t bc_i,
  input  ffca_tok_t   tok_i,
  output ffca_tok_t   tok_o
);

  localparam int POS_W = LEN_W + 1;

  logic [CELL_W-1:0]  map_q, map_d;
  logic [CELL_W-1:0]  avail;
  logic [CELL_W-1:0]  hit;
  logic               hit_any;
  logic [CELL_IW-1:0] hit_idx;
  logic [LEN_W-1:0]   start_new;
  logic [LEN_W-1:0]   run_new;
  ffca_tok_t          tok_q, tok_d;

  function automatic logic [POS_W-1:0] pos_of(input int i);
    return POS_W'(BASE + i);
  endfunction

  function automatic logic reach_of(input int i);
    return (BASE + i) < (1 << LEN_W);
  endfunction

  // Availability of each bit, plus set and clear updates
  always_comb begin
    logic [CELL_W-1:0] set_hit;
    logic [CELL_W-1:0] clr_hit;
    logic [POS_W-1:0]  pos;
    set_hit = '0;
    clr_hit = '0;
    for (int i = 0; i < CELL_W; i++) begin
      pos        = pos_of(i);
      avail[i]   = map_q[i] && reach_of(i) && (pos < {1'b0, bc_i.lim});
      set_hit[i] = bc_i.set && reach_of(i) && (pos == {1'b0, bc_i.set_pos});
      clr_hit[i] = bc_i.clr && reach_of(i) && (pos >= {1'b0, bc_i.clr_lo})
                   && (pos < bc_i.clr_hi);
    end
    map_d = (map_q | set_hit) & ~clr_hit;
  end

  // Find, for each bit, whether a run of the requested length ends there
  always_comb begin
    logic [CELL_W-1:0] lowm;
    logic [CELL_W-1:0] winm;
    logic [POS_W-1:0]  sum;
    logic              pre_hit;
    logic              loc_hit;
    for (int i = 0; i < CELL_W; i++) begin
      lowm    = {CELL_W{1'b1}} >> (CELL_W - 1 - i);
      sum     = {1'b0, tok_i.run} + POS_W'(i + 1);
      pre_hit = ((avail & lowm) == lowm) && (sum >= {1'b0, bc_i.len});
      loc_hit = 1'b0;
      for (int k = 1; k <= CELL_W; k++) begin
        if (k <= i + 1) begin
          winm = {CELL_W{1'b1}} >> (CELL_W - k);
          winm = winm << (i - k + 1);
          if ((bc_i.len == LEN_W'(k)) && ((avail & winm) == winm)) begin
            loc_hit = 1'b1;
          end
        end
      end
      hit[i] = pre_hit || loc_hit;
    end
  end

  // Pick the lowest ending bit and the free tail handed to the next cell
  always_comb begin
    logic             zero_seen;
    logic [LEN_W-1:0] tail;
    hit_any   = 1'b0;
    hit_idx   = '0;
    zero_seen = 1'b0;
    tail      = '0;
    for (int i = 0; i < CELL_W; i++) begin
      if (hit[i] && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = CELL_IW'(i);
      end
    end
    for (int i = CELL_W - 1; i >= 0; i--) begin
      if (!avail[i] && !zero_seen) begin
        zero_seen = 1'b1;
        tail      = LEN_W'(CELL_W - 1 - i);
      end
    end
    run_new   = zero_seen ? tail : (tok_i.run + LEN_W'(CELL_W));
    start_new = LEN_W'(BASE + 1) + LEN_W'(hit_idx) - bc_i.len;
  end

  // Advance the token
  always_comb begin
    tok_d       = tok_i;
    tok_d.run   = run_new;
    if (tok_i.act && !tok_i.found && hit_any) begin
      tok_d.found = 1'b1;
      tok_d.start = start_new;
    end
  end

  // Hold the map slice and the token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
      tok_q <= '0;
    end else begin
      map_q <= map_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/first_fit_contiguous_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator_top: first-fit contiguous block allocator
// Free map spread over a chain of cells, scanned by a token for the lowest
// run of free blocks that fits a request.
// ----------------------------------------------------------------------------
// The free map is split into cells of 16 blocks each (64 cells for 1024
// blocks). A load transaction leaves the controller idle and registers a set
// broadcast, from which the cell marks the block free. An allocate
// transaction sends a scan token through the chain, one cell per cycle,
// and the next request is taken only after its result has been loaded;
// a zero length or one above the usable block count skips the scan. The
// result sits in an output register, so the next request is accepted while
// it waits. The granted run is cleared in the cycle after the result is
// loaded. Reset leaves every block used, block count min(MAX_BLOCKS, 1024).
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator_top import ffca_pkg::*; #(
  parameter int MAX_BLOCKS = FFCA_MAX_BLOCKS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  ffca_req_if.sink         req_i,
  ffca_rsp_if.source       rsp_o
);

  localparam int NCELLS = (MAX_BLOCKS + CELL_W - 1) / CELL_W;
  localparam logic [LEN_W-1:0] LIM_RST =
    (MAX_BLOCKS < int'(DISK_BLOCKS_RST)) ? LEN_W'(MAX_BLOCKS) : DISK_BLOCKS_RST;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PUSH} state_e;

  state_e           state_q;
  logic [LEN_W-1:0] lim_q;
  logic [LEN_W-1:0] len_q;
  logic             set_q;
  logic [LEN_W-1:0] set_pos_q;
  logic             clr_q;
  logic [LEN_W-1:0] clr_lo_q;
  logic [LEN_W:0]   clr_hi_q;
  logic             scan_go_q;
  logic             res_ok_q;
  logic [LEN_W-1:0] res_start_q;
  logic             out_valid_q;
  logic             out_granted_q;
  logic [IDX_W-1:0] out_start_q;
  logic [LEN_W-1:0] out_len_q;
  logic [LEN_W-1:0] lim_d;
  logic             req_acc;

  ffca_bcast_t bc;
  ffca_tok_t   tok [NCELLS+1];

  // Saturate the written block count at the map size
  assign lim_d = (int'(cfg_data_i) > MAX_BLOCKS) ? LEN_W'(MAX_BLOCKS) : cfg_data_i;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // Broadcast to the cells
  assign bc = '{set: set_q, set_pos: set_pos_q, clr: clr_q, clr_lo: clr_lo_q,
                clr_hi: clr_hi_q, len: len_q, lim: lim_q};

  // Inject the scan token
  assign tok[0] = '{act: scan_go_q, found: 1'b0, run: '0, start: '0};

  // Build the cell chain
  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    ffca_cell #(
      .BASE(c * CELL_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .bc_i  (bc),
      .tok_i (tok[c]),
      .tok_o (tok[c+1])
    );
  end

  // Control sequence and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      lim_q         <= LIM_RST;
      set_q         <= 1'b0;
      clr_q         <= 1'b0;
      scan_go_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      len_q         <= '0;
      set_pos_q     <= '0;
      clr_lo_q      <= '0;
      clr_hi_q      <= '0;
      res_ok_q      <= 1'b0;
      res_start_q   <= '0;
      out_granted_q <= 1'b0;
      out_start_q   <= '0;
      out_len_q     <= '0;
    end else begin
      set_q     <= 1'b0;
      clr_q     <= 1'b0;
      scan_go_q <= 1'b0;
      if (cfg_we_i) begin
        lim_q <= lim_d;
      end
      // Drop the result once taken
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            if (!req_i.mode) begin
              if ({1'b0, req_i.block_index} < lim_q) begin
                set_q     <= 1'b1;
                set_pos_q <= {1'b0, req_i.block_index};
              end
            end else begin
              len_q       <= req_i.request_length;
              res_start_q <= '0;
              if (req_i.request_length == '0) begin
                res_ok_q <= 1'b1;
                state_q  <= ST_PUSH;
              end else if (req_i.request_length > lim_q) begin
                res_ok_q <= 1'b0;
                state_q  <= ST_PUSH;
              end else begin
                scan_go_q <= 1'b1;
                state_q   <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (tok[NCELLS].act) begin
            res_ok_q    <= tok[NCELLS].found;
            res_start_q <= tok[NCELLS].found ? tok[NCELLS].start : '0;
            state_q     <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q   <= 1'b1;
            out_granted_q <= res_ok_q;
            out_start_q   <= res_start_q[IDX_W-1:0];
            out_len_q     <= res_ok_q ? len_q : '0;
            clr_q         <= res_ok_q;
            clr_lo_q      <= res_start_q;
            clr_hi_q      <= {1'b0, res_start_q} + {1'b0, len_q};
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted      = out_granted_q;
  assign rsp_o.start_block  = out_start_q;
  assign rsp_o.grant_length = out_len_q;

  // An allocate transaction always leaves idle
  a_alloc_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && req_i.mode |=> state_q != ST_IDLE)
    else $error("allocate transaction did not start processing");

  // The token only leaves the chain while a scan is pending
  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[NCELLS].act |-> state_q == ST_SCAN)
    else $error("scan token left the chain outside a scan");

  // Set and clear broadcasts never overlap
  a_bcast_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(set_q && clr_q))
    else $error("set and clear broadcast in the same cycle");

  // A failed allocation reports zero start and length
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.granted |-> rsp_o.start_block == '0
      && rsp_o.grant_length == '0)
    else $error("failed allocation with nonzero fields");

endmodule

// ----- tb/ffca_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_tb_pkg: verification definitions of the first-fit allocator
// Request mode codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package ffca_tb_pkg;

  // Request mode carried by the mode field of a request transaction
  typedef enum logic {
    MODE_FREE  = 1'b0,
    MODE_ALLOC = 1'b1
  } req_mode_e;

endpackage

// ----- tb/ffca_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_checker: passive checker of the first-fit allocator
// Watches the configuration port and both channels, keeps its own free map,
// predicts the outcome of every allocate transaction and compares each
// response transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ffca_checker import ffca_pkg::*; import ffca_tb_pkg::*; #(
  parameter int MAX_BLOCKS = FFCA_MAX_BLOCKS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  ffca_req_if              req,
  ffca_rsp_if              rsp,
  output int               mismatch_count,
  output int               grants_pending
);

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] start_block;
    logic [LEN_W-1:0] grant_length;
  } grant_t;

  // Shadow state: one bit per block, set means free
  logic             free_map [MAX_BLOCKS];
  logic [LEN_W-1:0] disk_blocks;
  grant_t           grants_due [$];

  // Clamp the configured block count to the map size
  function automatic int usable_blocks();
    return (disk_blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(disk_blocks);
  endfunction

  // Find the lowest run of len free blocks, claim it and build the response
  function automatic grant_t first_fit_grant(input logic [LEN_W-1:0] len);
    grant_t g;
    int     lim;
    int     run;
    int     base;
    bit     hit;
    g    = '0;
    lim  = usable_blocks();
    run  = 0;
    base = 0;
    hit  = (len == 0);
    if (!hit && len <= lim) begin
      for (int j = 0; j < lim && !hit; j++) begin
        if (free_map[j]) begin
          run++;
          if (run == len) begin
            base = j + 1 - int'(len);
            hit  = 1'b1;
          end
        end else begin
          run = 0;
        end
      end
    end
    if (hit) begin
      for (int j = 0; j < len; j++) free_map[base + j] = 1'b0;
      g.granted      = 1'b1;
      g.start_block  = base[IDX_W-1:0];
      g.grant_length = len;
    end
    return g;
  endfunction

  // Compare responses first: a response never belongs to a request of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t got;
    grant_t want;
    int     bad;
    if (!rst_ni) begin
      foreach (free_map[k]) free_map[k] = 1'b0;
      disk_blocks = DISK_BLOCKS_RST;
      grants_due.delete();
      mismatch_count <= 0;
      grants_pending <= 0;
    end else begin
      bad = 0;
      if (rsp.valid && rsp.ready) begin
        got.granted      = rsp.granted;
        got.start_block  = rsp.start_block;
        got.grant_length = rsp.grant_length;
        if (grants_due.size() == 0) begin
          $error("unexpected response: granted=%0d start_block=%0d grant_length=%0d",
                 got.granted, got.start_block, got.grant_length);
          bad++;
        end else begin
          want = grants_due.pop_front();
          if (got.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, got.granted);
            bad++;
          end
          if (got.start_block !== want.start_block) begin
            $error("start_block: expected %0d, got %0d", want.start_block, got.start_block);
            bad++;
          end
          if (got.grant_length !== want.grant_length) begin
            $error("grant_length: expected %0d, got %0d", want.grant_length,
                   got.grant_length);
            bad++;
          end
        end
      end
      // Apply the accepted request to the shadow map
      if (req.valid && req.ready) begin
        if (req.mode == MODE_ALLOC) begin
          grants_due.push_back(first_fit_grant(req.request_length));
        end else if (req.block_index < usable_blocks()) begin
          free_map[req.block_index] = 1'b1;
        end
      end
      if (cfg_we_i) disk_blocks = cfg_data_i;
      mismatch_count <= mismatch_count + bad;
      grants_pending <= grants_due.size();
    end
  end

endmodule

// ----- tb/tb_first_fit_contiguous_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_contiguous_allocator_top: testbench of the first-fit allocator
// Drives directed and random free and allocate transactions through several
// block count settings, with random gaps on the request side and random
// stalls on the response side. The checker predicts and compares; this
// module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_first_fit_contiguous_allocator_top;
  import ffca_pkg::*;
  import ffca_tb_pkg::*;

  localparam int MAX_BLOCKS    = FFCA_MAX_BLOCKS;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 3000000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_data_i;
  int               mismatch_count;
  int               grants_pending;
  int               ready_hold;
  bit               req_gaps;
  bit               rsp_stalls;

  ffca_req_if req_if ();
  ffca_rsp_if rsp_if ();

  first_fit_contiguous_allocator_top #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  ffca_checker #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .req           (req_if),
    .rsp           (rsp_if),
    .mismatch_count(mismatch_count),
    .grants_pending(grants_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
  endfunction

  // Stall the response channel at random while stalls are enabled
  always @(posedge clk_i) begin
    if (!rsp_stalls) begin
      rsp_if.ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold   <= ready_hold - 1;
      rsp_if.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      ready_hold   <= gap_len();
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Send one request; returns right after the edge that accepts it
  task automatic send_req(input req_mode_e m, input logic [IDX_W-1:0] idx,
                          input logic [LEN_W-1:0] len);
    int gap;
    gap = req_gaps ? gap_len() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.mode           <= m;
    req_if.block_index    <= idx;
    req_if.request_length <= len;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Hold off until every predicted response is back and the block has settled
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (grants_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_disk_blocks(input logic [LEN_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One block count setting with a random mix of frees, free bursts and allocations
  task automatic run_phase(input logic [LEN_W-1:0] blocks, input int quota,
                           input bit gaps, input bit stalls);
    int               done;
    int               lim;
    int               pick;
    int               lo;
    int               cnt;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    wait_idle();
    write_disk_blocks(blocks);
    req_gaps   = gaps;
    rsp_stalls = stalls;
    lim        = (blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks);
    done       = 0;
    while (done < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 8 && lim > 0) begin
        lo  = $urandom_range(0, lim - 1);
        cnt = $urandom_range(1, (lim - lo < 32) ? lim - lo : 32);
        for (int k = 0; k < cnt; k++) begin
          send_req(MODE_FREE, IDX_W'(lo + k), LEN_W'($urandom));
        end
        done += cnt;
      end else if (pick < 50) begin
        idx = (lim > 0 && $urandom_range(0, 9) != 0) ? IDX_W'($urandom_range(0, lim - 1))
                                                     : IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
        send_req(MODE_FREE, idx, LEN_W'($urandom));
        if (idx < lim) done++;
      end else begin
        case ($urandom_range(0, 19))
          0:       len = '0;
          1:       len = LEN_W'($urandom);
          2:       len = LEN_W'(lim);
          3:       len = LEN_W'(lim + 1);
          default: len = LEN_W'($urandom_range(1, 24));
        endcase
        send_req(MODE_ALLOC, IDX_W'($urandom), len);
        done++;
      end
      // Drain now and then in the middle of a phase
      if ($urandom_range(0, 149) == 0) wait_idle();
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_data_i            = '0;
    req_if.valid          = 1'b0;
    req_if.mode           = MODE_FREE;
    req_if.block_index    = '0;
    req_if.request_length = '0;
    rsp_if.ready          = 1'b0;
    ready_hold            = 0;
    req_gaps              = 1'b1;
    rsp_stalls            = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero length, empty map, edge blocks, repeated free, oversized
    send_req(MODE_ALLOC, '0, '0);
    send_req(MODE_ALLOC, '0, 11'd1);
    send_req(MODE_FREE, 10'd1023, '0);
    send_req(MODE_FREE, 10'd0, '0);
    send_req(MODE_FREE, 10'd0, '0);
    send_req(MODE_FREE, 10'd1, '0);
    send_req(MODE_ALLOC, '0, 11'd2);
    send_req(MODE_ALLOC, '0, 11'd1);
    send_req(MODE_ALLOC, '0, 11'd1);
    send_req(MODE_ALLOC, '0, 11'd1024);
    send_req(MODE_ALLOC, '0, 11'd1025);
    send_req(MODE_ALLOC, 10'd1023, 11'd2047);
    send_req(MODE_FREE, 10'd682, '0);
    send_req(MODE_FREE, 10'd341, '0);
    send_req(MODE_FREE, 10'd512, '0);
    send_req(MODE_ALLOC, '0, 11'd1);
    send_req(MODE_ALLOC, '0, 11'd1);
    send_req(MODE_ALLOC, '0, 11'd1);
    send_req(MODE_ALLOC, '0, '0);

    // Free the whole map, then take all of it in one run
    wait_idle();
    write_disk_blocks(11'd1024);
    for (int k = 0; k < MAX_BLOCKS; k++) send_req(MODE_FREE, IDX_W'(k), '0);
    send_req(MODE_ALLOC, '0, 11'd1024);
    send_req(MODE_ALLOC, '0, 11'd1);

    run_phase(11'd1024, 150, 1'b1, 1'b1);
    run_phase(11'd1,     60, 1'b1, 1'b0);
    run_phase(11'd64,   150, 1'b0, 1'b1);
    run_phase(11'd0,     40, 1'b1, 1'b1);
    run_phase(11'd2047, 150, 1'b0, 1'b0);
    run_phase(11'd300,  120, 1'b1, 1'b1);
    run_phase(11'd17,    60, 1'b1, 1'b1);
    run_phase(11'd1024, 100, 1'b1, 1'b1);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- first_fit_contiguous_allocator_top.f -----
rtl/ffca_pkg.sv
rtl/ffca_req_if.sv
rtl/ffca_rsp_if.sv
rtl/ffca_cell.sv
rtl/first_fit_contiguous_allocator_top.sv
tb/ffca_tb_pkg.sv
tb/ffca_checker.sv
tb/tb_first_fit_contiguous_allocator_top.sv
